[sv/bsq_pkg.sv]
// Shared types, constants and register codes of the battery sample qualifier.
`timescale 1ns / 1ps

package bsq_pkg;

   localparam int LEVEL_W    = 15;
   localparam int RAW_W      = 16;
   localparam int VOLTS_W    = 16;
   localparam int COUNT_W    = 3;
   localparam int TDATA_W    = 40;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam int HISTORY_DEPTH = 5;
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
   localparam int SUM_W         = VOLTS_W + 2;

   localparam logic [RAW_W-1:0] FAILED_READ = 16'hFFFF;

   // Strict (startup) window
   localparam logic [RAW_W-1:0]   STRICT_LEVEL_MIN = 16'd2560;
   localparam logic [RAW_W-1:0]   STRICT_LEVEL_MAX = 16'd24320;
   localparam logic [VOLTS_W-1:0] STRICT_VOLTS_MIN = 16'd38400;
   localparam logic [VOLTS_W-1:0] STRICT_VOLTS_MAX = 16'd57600;
   // Permissive window
   localparam logic [RAW_W-1:0]   LOOSE_LEVEL_MAX  = 16'd25600;
   localparam logic [VOLTS_W-1:0] LOOSE_VOLTS_MIN  = 16'd32000;
   localparam logic [VOLTS_W-1:0] LOOSE_VOLTS_MAX  = 16'd64000;

   localparam logic [RAW_W-1:0]   CORRUPT_LEVEL_MAX = 16'd1280;
   localparam logic [VOLTS_W-1:0] CORRUPT_VOLTS_MIN = 16'd38400;
   localparam logic [COUNT_W-1:0] CORRUPT_COUNT_MIN = 3'd3;
   localparam logic [COUNT_W-1:0] FALLBACK_COUNT    = 3'd5;

   localparam logic [SUM_W-1:0] RISE_MARGIN = 18'd512;

   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 15'd19200;
   localparam logic [VOLTS_W-1:0] VOLTS_RESET = 16'd47360;

   localparam logic [LEVEL_W-1:0] LOW_LEVEL_RESET     = 15'd3840;
   localparam logic [VOLTS_W-1:0] CRITICAL_RESET      = 16'd42240;
   localparam logic [VOLTS_W-1:0] CHARGE_SURE_RESET   = 16'd53120;
   localparam logic [VOLTS_W-1:0] CHARGE_LIKELY_RESET = 16'd51840;
   localparam logic [VOLTS_W-1:0] CHARGE_STOP_RESET   = 16'd49920;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LEVEL     = 3'd0,
      CSR_CRITICAL      = 3'd1,
      CSR_CHARGE_SURE   = 3'd2,
      CSR_CHARGE_LIKELY = 3'd3,
      CSR_CHARGE_STOP   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] low_level_threshold;
      logic [VOLTS_W-1:0] critical_voltage;
      logic [VOLTS_W-1:0] charge_sure_voltage;
      logic [VOLTS_W-1:0] charge_likely_voltage;
      logic [VOLTS_W-1:0] charge_stop_voltage;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0]   level_raw;
      logic [VOLTS_W-1:0] cell_raw;
      logic               in_startup;
      logic               charge_tick;
   } req_item_type;

   typedef struct packed {
      logic               accepted;
      logic [LEVEL_W-1:0] level_now;
      logic [VOLTS_W-1:0] volts_now;
      logic               charging;
      logic               low_battery;
      logic               low_onset;
      logic               critical;
      logic               corrupt_suspect;
      logic               fallback_request;
   } rsp_item_type;

endpackage

[sv/battery_sample_qualifier.sv]
// Top level of the battery sample qualifier: ports, register file and stage control.
`timescale 1ns / 1ps

// Qualifies one raw fuel-gauge sample per item. Each request item carries a
// charge level (1/256 percent) and a cell voltage (78.125 uV units), with
// 0xFFFF in either marking a failed read, plus a startup flag that selects
// the strict acceptance window and a tick that runs the charging decision.
// Each request item yields exactly one response item with the stored level
// and voltage, the charging state, and the low-battery, low-onset, critical,
// corrupt-suspect and fallback flags. Each item is held in the input register,
// its whole update (window check, reject counter, five-entry voltage history,
// trend and hysteresis, warning flags) is done in a single pass into the
// result register, and one item is taken every cycle while the response side
// keeps up. Configuration writes through the csr_ port apply at once; make
// them only while no item is in flight. Indexes above four are ignored.

module battery_sample_qualifier (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: level_raw[15:0], cell_raw[31:16], in_startup[32],
   //            charge_tick[33], zero[39:34]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bsq_pkg::TDATA_W-1:0]     req_tdata,
   // rsp_tdata: accepted[0], level_now[15:1], volts_now[31:16], charging[32],
   //            low_battery[33], low_onset[34], critical[35],
   //            corrupt_suspect[36], fallback_request[37], zero[39:38]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bsq_pkg::TDATA_W-1:0]     rsp_tdata,
   input  logic                            csr_we,
   input  logic [bsq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bsq_pkg::cfg_type      cfg_ff;
   bsq_pkg::cfg_type      cfg_in;
   bsq_pkg::req_item_type held_item;
   bsq_pkg::rsp_item_type result;
   logic                  held_valid;
   logic                  take;

   // Register file: decode the index, drop writes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bsq_pkg::CSR_LOW_LEVEL: begin
               cfg_in.low_level_threshold = csr_wdata[bsq_pkg::LEVEL_W-1:0];
            end
            bsq_pkg::CSR_CRITICAL: begin
               cfg_in.critical_voltage = csr_wdata;
            end
            bsq_pkg::CSR_CHARGE_SURE: begin
               cfg_in.charge_sure_voltage = csr_wdata;
            end
            bsq_pkg::CSR_CHARGE_LIKELY: begin
               cfg_in.charge_likely_voltage = csr_wdata;
            end
            bsq_pkg::CSR_CHARGE_STOP: begin
               cfg_in.charge_stop_voltage = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_level_threshold   <= bsq_pkg::LOW_LEVEL_RESET;
         cfg_ff.critical_voltage      <= bsq_pkg::CRITICAL_RESET;
         cfg_ff.charge_sure_voltage   <= bsq_pkg::CHARGE_SURE_RESET;
         cfg_ff.charge_likely_voltage <= bsq_pkg::CHARGE_LIKELY_RESET;
         cfg_ff.charge_stop_voltage   <= bsq_pkg::CHARGE_STOP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance the held item whenever the result register is free or emptying
   assign take = held_valid && (!rsp_tvalid || rsp_tready);

   bsq_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   bsq_track u_track (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (held_item),
      .cfg    (cfg_ff),
      .result (result)
   );

   bsq_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[sv/bsq_in_reg.sv]
// Input register of the battery sample qualifier: holds one request item.
`timescale 1ns / 1ps

module bsq_in_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bsq_pkg::TDATA_W-1:0]  req_tdata,
   input  logic                         take,
   output logic                         held_valid,
   output bsq_pkg::req_item_type        held_item
);

   logic                  valid_ff;
   logic                  valid_in;
   bsq_pkg::req_item_type item_ff;
   bsq_pkg::req_item_type item_in;
   logic                  load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      item_in.level_raw   = req_tdata[15:0];
      item_in.cell_raw    = req_tdata[31:16];
      item_in.in_startup  = req_tdata[32];
      item_in.charge_tick = req_tdata[33];
      valid_in = load || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

[sv/bsq_track.sv]
// Qualifier state and the single-pass update for one sample.
`timescale 1ns / 1ps

module bsq_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  bsq_pkg::req_item_type item,
   input  bsq_pkg::cfg_type      cfg,
   output bsq_pkg::rsp_item_type result
);

   logic [bsq_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [bsq_pkg::VOLTS_W-1:0] volts_ff, volts_in;
   logic [bsq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bsq_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [bsq_pkg::VOLTS_W-1:0] hist_ff [bsq_pkg::HISTORY_DEPTH];
   logic [bsq_pkg::VOLTS_W-1:0] hist_in [bsq_pkg::HISTORY_DEPTH];
   logic                        charging_ff, charging_in;
   logic                        low_ff, low_in;

   logic                        ok;
   logic                        ok_strict, ok_loose;
   logic [bsq_pkg::COUNT_W-1:0] count_inc, count_mid;
   logic                        corrupt, fallback, onset;
   logic [bsq_pkg::SLOT_W-1:0]  slot_eff;
   logic [bsq_pkg::SUM_W-1:0]   newer, older;
   logic                        rising;

   always_comb begin
      ok_strict = item.level_raw >= bsq_pkg::STRICT_LEVEL_MIN
               && item.level_raw <= bsq_pkg::STRICT_LEVEL_MAX
               && item.cell_raw  >  bsq_pkg::STRICT_VOLTS_MIN
               && item.cell_raw  <  bsq_pkg::STRICT_VOLTS_MAX;
      ok_loose  = item.level_raw <= bsq_pkg::LOOSE_LEVEL_MAX
               && item.cell_raw  >  bsq_pkg::LOOSE_VOLTS_MIN
               && item.cell_raw  <  bsq_pkg::LOOSE_VOLTS_MAX;
      ok = item.in_startup ? ok_strict : ok_loose;

      // Reject path: count, then corrupt check, then fallback check
      count_inc = count_ff + 1'b1;
      corrupt   = !ok && item.in_startup && count_inc > bsq_pkg::CORRUPT_COUNT_MIN
               && (item.level_raw == bsq_pkg::FAILED_READ
                   || item.level_raw < bsq_pkg::CORRUPT_LEVEL_MAX)
               && item.cell_raw != bsq_pkg::FAILED_READ
               && item.cell_raw > bsq_pkg::CORRUPT_VOLTS_MIN;
      count_mid = corrupt ? '0 : count_inc;
      fallback  = !ok && count_mid > bsq_pkg::FALLBACK_COUNT;

      if (ok) begin
         level_in = item.level_raw[bsq_pkg::LEVEL_W-1:0];
         volts_in = item.cell_raw;
         count_in = '0;
      end else begin
         level_in = level_ff;
         volts_in = volts_ff;
         count_in = fallback ? '0 : count_mid;
      end

      // History write and trend
      slot_eff = (slot_ff >= bsq_pkg::SLOT_W'(bsq_pkg::HISTORY_DEPTH)) ? '0 : slot_ff;
      slot_in  = slot_ff;
      if (item.charge_tick) begin
         slot_in = (slot_eff == bsq_pkg::SLOT_W'(bsq_pkg::HISTORY_DEPTH - 1)) ? '0
                 : slot_eff + 1'b1;
      end
      for (int i = 0; i < bsq_pkg::HISTORY_DEPTH; i++) begin
         hist_in[i] = (item.charge_tick && slot_eff == bsq_pkg::SLOT_W'(i)) ? volts_in
                    : hist_ff[i];
      end
      newer  = bsq_pkg::SUM_W'(hist_in[3]) + bsq_pkg::SUM_W'(hist_in[4]);
      older  = bsq_pkg::SUM_W'(hist_in[0]) + bsq_pkg::SUM_W'(hist_in[1])
             + bsq_pkg::RISE_MARGIN;
      rising = newer > older;

      charging_in = charging_ff;
      if (item.charge_tick) begin
         if (volts_in > cfg.charge_sure_voltage
             || (volts_in > cfg.charge_likely_voltage && rising)) begin
            charging_in = 1'b1;
         end else if (volts_in < cfg.charge_stop_voltage) begin
            charging_in = 1'b0;
         end
      end

      if (charging_in) begin
         low_in = 1'b0;
         onset  = 1'b0;
      end else begin
         low_in = level_in < cfg.low_level_threshold;
         onset  = low_in && !low_ff;
      end

      result.accepted         = ok;
      result.level_now        = level_in;
      result.volts_now        = volts_in;
      result.charging         = charging_in;
      result.low_battery      = low_in;
      result.low_onset        = onset;
      result.critical         = volts_in < cfg.critical_voltage;
      result.corrupt_suspect  = corrupt;
      result.fallback_request = fallback;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= bsq_pkg::LEVEL_RESET;
         volts_ff    <= bsq_pkg::VOLTS_RESET;
         count_ff    <= '0;
         slot_ff     <= '0;
         charging_ff <= 1'b0;
         low_ff      <= 1'b0;
         for (int i = 0; i < bsq_pkg::HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (take) begin
         level_ff    <= level_in;
         volts_ff    <= volts_in;
         count_ff    <= count_in;
         slot_ff     <= slot_in;
         charging_ff <= charging_in;
         low_ff      <= low_in;
         for (int i = 0; i < bsq_pkg::HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

endmodule

[sv/bsq_out_reg.sv]
// Result register of the battery sample qualifier: holds one response item.
`timescale 1ns / 1ps

module bsq_out_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  bsq_pkg::rsp_item_type        result,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bsq_pkg::TDATA_W-1:0]  rsp_tdata
);

   logic                  valid_ff;
   logic                  valid_in;
   bsq_pkg::rsp_item_type item_ff;

   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b0,
                        item_ff.fallback_request,
                        item_ff.corrupt_suspect,
                        item_ff.critical,
                        item_ff.low_onset,
                        item_ff.low_battery,
                        item_ff.charging,
                        item_ff.volts_now,
                        item_ff.level_now,
                        item_ff.accepted};

endmodule

[bench/tb_battery_sample_qualifier.sv]
// Self-checking testbench of the battery sample qualifier: stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_battery_sample_qualifier;
   import bsq_pkg::*;

   // Two register stages between the request and the response handshake.
   localparam int DUT_LATENCY  = 2;
   localparam int SETTLE_LIMIT = 5000;
   localparam int REPORT_LIMIT = 40;

   typedef enum {
      RUN_GOOD,    // samples near the window edges and thresholds
      RUN_RAMP,    // steady voltage ramp with charge ticks, drives the trend logic
      RUN_REJECT,  // bursts of failed or tiny readings, reaches corrupt and fallback
      RUN_NOISE    // fully random fields
   } run_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // req_tdata: level_raw[15:0], cell_raw[31:16], in_startup[32], charge_tick[33]
   logic [TDATA_W-1:0]    req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // rsp_tdata: accepted[0], level_now[15:1], volts_now[31:16], charging[32],
   //            low_battery[33], low_onset[34], critical[35],
   //            corrupt_suspect[36], fallback_request[37]
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted copy of the qualifier's state and registers.
   cfg_type               pred_cfg;
   logic [LEVEL_W-1:0]    pred_level;
   logic [VOLTS_W-1:0]    pred_volts;
   logic [COUNT_W-1:0]    pred_rejects;
   logic [VOLTS_W-1:0]    pred_history [HISTORY_DEPTH];
   int                    pred_slot;
   logic                  pred_charging;
   logic                  pred_low;

   rsp_item_type          pending_results [$];
   rsp_item_type          want_rsp;

   // Idle shaping, changed by the tests while the run goes on.
   int                    req_gap_pct;
   int                    rsp_stall_pct;
   int                    hold_request;

   int unsigned           failures;
   int unsigned           samples_sent;
   int unsigned           results_checked;
   int unsigned           accepted_seen;
   int unsigned           corrupt_seen;
   int unsigned           fallback_seen;
   int unsigned           onset_seen;
   int unsigned           charging_seen;

   battery_sample_qualifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("%0t ns: run did not finish in time", $time);
      $display("FAIL");
      $finish;
   end

   function automatic logic [15:0] rand16(int unsigned lo, int unsigned hi);
      int unsigned x;
      x = $urandom_range(hi, lo);
      return x[15:0];
   endfunction

   function automatic logic rand_bit(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Voltage near one of the register thresholds or window edges.
   function automatic logic [15:0] near_volts();
      int v;
      case ($urandom_range(0, 7))
         0: v = int'(pred_cfg.critical_voltage);
         1: v = int'(pred_cfg.charge_sure_voltage);
         2: v = int'(pred_cfg.charge_likely_voltage);
         3: v = int'(pred_cfg.charge_stop_voltage);
         4: v = int'(STRICT_VOLTS_MIN);
         5: v = int'(STRICT_VOLTS_MAX);
         6: v = int'(LOOSE_VOLTS_MIN);
         default: v = int'(LOOSE_VOLTS_MAX);
      endcase
      v = v + int'($urandom_range(0, 800)) - 400;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // Level near the low threshold or a window edge, or anywhere in range.
   function automatic logic [15:0] near_level();
      int v;
      case ($urandom_range(0, 6))
         0: v = int'(pred_cfg.low_level_threshold);
         1: v = int'(STRICT_LEVEL_MIN);
         2: v = int'(STRICT_LEVEL_MAX);
         3: v = int'(LOOSE_LEVEL_MAX);
         4: v = int'(CORRUPT_LEVEL_MAX);
         default: v = int'($urandom_range(0, 25600));
      endcase
      v = v + int'($urandom_range(0, 40)) - 20;
      if (v < 0) v = 0;
      return v[15:0];
   endfunction

   // Work out the response to one sample and advance the predicted state.
   function automatic rsp_item_type predict_sample(req_item_type s);
      rsp_item_type r;
      logic         ok;
      logic         corrupt;
      logic         fallback;
      logic         onset;
      logic         was_low;
      logic         rising;
      int unsigned  older;
      int unsigned  newer;
      corrupt  = 1'b0;
      fallback = 1'b0;
      onset    = 1'b0;
      if (s.in_startup)
         ok = s.level_raw >= STRICT_LEVEL_MIN && s.level_raw <= STRICT_LEVEL_MAX &&
              s.cell_raw > STRICT_VOLTS_MIN && s.cell_raw < STRICT_VOLTS_MAX;
      else
         ok = s.level_raw <= LOOSE_LEVEL_MAX &&
              s.cell_raw > LOOSE_VOLTS_MIN && s.cell_raw < LOOSE_VOLTS_MAX;
      if (ok) begin
         pred_level   = s.level_raw[LEVEL_W-1:0];
         pred_volts   = s.cell_raw;
         pred_rejects = '0;
      end else begin
         pred_rejects = pred_rejects + 1'b1;
         if (s.in_startup && pred_rejects > CORRUPT_COUNT_MIN &&
             (s.level_raw == FAILED_READ || s.level_raw < CORRUPT_LEVEL_MAX) &&
             s.cell_raw != FAILED_READ && s.cell_raw > CORRUPT_VOLTS_MIN) begin
            corrupt      = 1'b1;
            pred_rejects = '0;
         end
         if (pred_rejects > FALLBACK_COUNT) begin
            fallback     = 1'b1;
            pred_rejects = '0;
         end
      end
      if (s.charge_tick) begin
         pred_history[pred_slot] = pred_volts;
         pred_slot = (pred_slot + 1) % HISTORY_DEPTH;
         older  = int'(pred_history[0]) + int'(pred_history[1]);
         newer  = int'(pred_history[3]) + int'(pred_history[4]);
         rising = newer > older + int'(RISE_MARGIN);
         if (pred_volts > pred_cfg.charge_sure_voltage ||
             (pred_volts > pred_cfg.charge_likely_voltage && rising))
            pred_charging = 1'b1;
         else if (pred_volts < pred_cfg.charge_stop_voltage)
            pred_charging = 1'b0;
      end
      if (pred_charging) begin
         pred_low = 1'b0;
      end else begin
         was_low  = pred_low;
         pred_low = pred_level < pred_cfg.low_level_threshold;
         onset    = pred_low && !was_low;
      end
      r.accepted         = ok;
      r.level_now        = pred_level;
      r.volts_now        = pred_volts;
      r.charging         = pred_charging;
      r.low_battery      = pred_low;
      r.low_onset        = onset;
      r.critical         = pred_volts < pred_cfg.critical_voltage;
      r.corrupt_suspect  = corrupt;
      r.fallback_request = fallback;
      return r;
   endfunction

   // Offer one sample, hold it until taken, predict, then sometimes idle a while.
   // Called and returns at a falling edge.
   task automatic send_sample(logic [15:0] level, logic [15:0] volts,
                              logic startup, logic tick);
      req_item_type s;
      int           gap;
      s.level_raw   = level;
      s.cell_raw    = volts;
      s.in_startup  = startup;
      s.charge_tick = tick;
      req_tdata  = {6'b0, tick, startup, volts, level};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_results.push_back(predict_sample(s));
      samples_sent++;
      @(negedge clock);
      gap = rand_bit(req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid, wait for every outstanding response, then let the pipe empty.
   task automatic wait_results_settled();
      int waited;
      req_tvalid = 1'b0;
      waited     = 0;
      while (pending_results.size() != 0 && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DUT_LATENCY + 2) @(negedge clock);
      if (pending_results.size() != 0) begin
         failures++;
         $display("%0t ns: %0d responses never arrived, expected 0 pending, actual %0d",
                  $time, pending_results.size(), pending_results.size());
         pending_results.delete();
      end
   endtask

   // Register write: one cycle of write enable, mirrored into the predictor.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         CSR_LOW_LEVEL:     pred_cfg.low_level_threshold   = val[LEVEL_W-1:0];
         CSR_CRITICAL:      pred_cfg.critical_voltage      = val;
         CSR_CHARGE_SURE:   pred_cfg.charge_sure_voltage   = val;
         CSR_CHARGE_LIKELY: pred_cfg.charge_likely_voltage = val;
         CSR_CHARGE_STOP:   pred_cfg.charge_stop_voltage   = val;
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [15:0] low_level, logic [15:0] crit,
                               logic [15:0] sure, logic [15:0] likely,
                               logic [15:0] stop);
      wait_results_settled();
      write_reg(CSR_LOW_LEVEL, low_level);
      write_reg(CSR_CRITICAL, crit);
      write_reg(CSR_CHARGE_SURE, sure);
      write_reg(CSR_CHARGE_LIKELY, likely);
      write_reg(CSR_CHARGE_STOP, stop);
   endtask

   // Edges of both acceptance windows, failed reads on either field.
   task automatic test_window_edges();
      send_sample(16'd2559, 16'd45000, 1'b1, 1'b0);
      send_sample(16'd2560, 16'd38401, 1'b1, 1'b1);
      send_sample(16'd24320, 16'd57599, 1'b1, 1'b0);
      send_sample(16'd24321, 16'd45000, 1'b1, 1'b1);
      send_sample(16'd10000, 16'd38400, 1'b1, 1'b0);
      send_sample(16'd10000, 16'd57600, 1'b1, 1'b0);
      send_sample(16'd25600, 16'd32001, 1'b0, 1'b1);
      send_sample(16'd25601, 16'd50000, 1'b0, 1'b0);
      send_sample(16'd0, 16'd63999, 1'b0, 1'b1);
      send_sample(16'd0, 16'd64000, 1'b0, 1'b0);
      send_sample(FAILED_READ, 16'd50000, 1'b0, 1'b1);
      send_sample(16'd10000, FAILED_READ, 1'b0, 1'b0);
   endtask

   // Startup rejects with a tiny level trip the corrupt flag; a long run of
   // failed reads trips the fallback request.
   task automatic test_reject_flags();
      repeat (4) send_sample(16'd0, 16'd40000, 1'b1, 1'b0);
      repeat (6) send_sample(FAILED_READ, FAILED_READ, 1'b0, 1'b0);
   endtask

   // Set charging above the sure voltage, clear it below the stop voltage.
   task automatic test_charge_hysteresis();
      send_sample(16'd0, 16'd53121, 1'b0, 1'b1);
      send_sample(16'd0, 16'd49919, 1'b0, 1'b1);
   endtask

   // Writes to indexes past the last register must change nothing.
   task automatic test_spare_registers();
      wait_results_settled();
      for (int i = int'(CSR_CHARGE_STOP) + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(i[CSR_IDX_W-1:0], 16'hFFFF);
      send_sample(16'd3000, 16'd42000, 1'b0, 1'b1);
      send_sample(16'd20000, 16'd52000, 1'b0, 1'b0);
   endtask

   task automatic run_random_samples(int unsigned count);
      run_kind_type kind;
      int           pick;
      int           run_len;
      int           ramp_v;
      int           ramp_dir;
      int unsigned  done;
      logic [15:0]  level;
      logic [15:0]  volts;
      logic         startup;
      logic         tick;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         kind = pick < 45 ? RUN_GOOD : pick < 70 ? RUN_RAMP :
                pick < 90 ? RUN_REJECT : RUN_NOISE;
         case (kind)
            RUN_RAMP:   run_len = $urandom_range(5, 15);
            RUN_REJECT: run_len = $urandom_range(3, 8);
            default:    run_len = $urandom_range(1, 6);
         endcase
         ramp_v   = $urandom_range(46000, 55000);
         ramp_dir = rand_bit(50) ? 1 : -1;
         // Now and then reshape the idling, sometimes to none at all.
         if ($urandom_range(0, 7) == 0) begin
            req_gap_pct   = rand_bit(30) ? 0 : $urandom_range(5, 50);
            rsp_stall_pct = rand_bit(30) ? 0 : $urandom_range(5, 50);
         end
         for (int i = 0; i < run_len && done < count; i++) begin
            case (kind)
               RUN_GOOD: begin
                  startup = rand_bit(25);
                  level   = near_level();
                  volts   = near_volts();
                  tick    = rand_bit(35);
               end
               RUN_RAMP: begin
                  ramp_v = ramp_v + ramp_dir * int'($urandom_range(0, 300));
                  if (ramp_v < 32001) ramp_v = 32001;
                  if (ramp_v > 63999) ramp_v = 63999;
                  startup = 1'b0;
                  level   = rand16(0, 25600);
                  volts   = ramp_v[15:0];
                  tick    = rand_bit(85);
               end
               RUN_REJECT: begin
                  startup = rand_bit(75);
                  level   = rand_bit(50) ? FAILED_READ : rand16(0, 1279);
                  case ($urandom_range(0, 2))
                     0:       volts = FAILED_READ;
                     1:       volts = rand16(38401, 65534);
                     default: volts = rand16(0, 38400);
                  endcase
                  tick = rand_bit(20);
               end
               default: begin
                  startup = rand_bit(50);
                  level   = rand16(0, 65535);
                  volts   = rand16(0, 65535);
                  tick    = rand_bit(50);
               end
            endcase
            send_sample(level, volts, startup, tick);
            done++;
         end
      end
   endtask

   // Random traffic under several register settings, the extremes among them.
   task automatic test_random_phases();
      logic [15:0] stop;
      logic [15:0] likely;
      logic [15:0] sure;
      run_random_samples(300);
      stop   = rand16(45000, 52000);
      likely = stop + rand16(0, 3000);
      sure   = likely + rand16(0, 3000);
      apply_config(rand16(0, 25600), rand16(32000, 57600), sure, likely, stop);
      run_random_samples(250);
      apply_config(16'd25600, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_samples(120);
      apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random_samples(120);
      apply_config({1'b0, LOW_LEVEL_RESET}, CRITICAL_RESET, CHARGE_SURE_RESET,
                   CHARGE_LIKELY_RESET, CHARGE_STOP_RESET);
   endtask

   // Hold the response side off for a long stretch while samples keep coming,
   // so the pipe fills and the request side stalls.
   task automatic test_backpressure();
      req_gap_pct  = 0;
      hold_request = 80;
      repeat (30)
         send_sample(near_level(), near_volts(), rand_bit(20), rand_bit(40));
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
      end
   endfunction

   // Response sink: random stalls, plus a long hold-off when asked for.
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && rand_bit(rsp_stall_pct)) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Compare each taken response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            failures++;
            $display("%0t ns: unexpected response, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            want_rsp = pending_results.pop_front();
            results_checked++;
            check_field("accepted", want_rsp.accepted, rsp_tdata[0]);
            check_field("level_now", want_rsp.level_now, rsp_tdata[15:1]);
            check_field("volts_now", want_rsp.volts_now, rsp_tdata[31:16]);
            check_field("charging", want_rsp.charging, rsp_tdata[32]);
            check_field("low_battery", want_rsp.low_battery, rsp_tdata[33]);
            check_field("low_onset", want_rsp.low_onset, rsp_tdata[34]);
            check_field("critical", want_rsp.critical, rsp_tdata[35]);
            check_field("corrupt_suspect", want_rsp.corrupt_suspect, rsp_tdata[36]);
            check_field("fallback_request", want_rsp.fallback_request, rsp_tdata[37]);
            accepted_seen += want_rsp.accepted;
            corrupt_seen  += want_rsp.corrupt_suspect;
            fallback_seen += want_rsp.fallback_request;
            onset_seen    += want_rsp.low_onset;
            charging_seen += want_rsp.charging;
         end
      end
   end

   initial begin
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      reset         = 1'b1;
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      hold_request  = 0;
      failures        = 0;
      samples_sent    = 0;
      results_checked = 0;
      accepted_seen   = 0;
      corrupt_seen    = 0;
      fallback_seen   = 0;
      onset_seen      = 0;
      charging_seen   = 0;
      // Predictor starts from the reset state of the block.
      pred_cfg.low_level_threshold   = LOW_LEVEL_RESET;
      pred_cfg.critical_voltage      = CRITICAL_RESET;
      pred_cfg.charge_sure_voltage   = CHARGE_SURE_RESET;
      pred_cfg.charge_likely_voltage = CHARGE_LIKELY_RESET;
      pred_cfg.charge_stop_voltage   = CHARGE_STOP_RESET;
      pred_level    = LEVEL_RESET;
      pred_volts    = VOLTS_RESET;
      pred_rejects  = '0;
      pred_slot     = 0;
      pred_charging = 1'b0;
      pred_low      = 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++)
         pred_history[i] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_window_edges();
      test_reject_flags();
      test_charge_hysteresis();
      test_spare_registers();
      test_random_phases();
      test_backpressure();
      wait_results_settled();

      $display("Sent %0d samples, checked %0d responses (%0d accepted, %0d with charging set)",
               samples_sent, results_checked, accepted_seen, charging_seen);
      $display("Saw %0d corrupt flags, %0d fallback requests, %0d low-battery onsets",
               corrupt_seen, fallback_seen, onset_seen);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
sv/bsq_pkg.sv
sv/bsq_in_reg.sv
sv/bsq_track.sv
sv/bsq_out_reg.sv
sv/battery_sample_qualifier.sv
bench/tb_battery_sample_qualifier.sv
